>>> src/mevs_pkg.sv
// shared types, constants and helpers for the max equal value span block
`timescale 1ns / 1ps

package mevs_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int VALUE_W      = 32;
	localparam int SPAN_W       = 11;
	localparam int ENTRY_W      = VALUE_W + IDX_W;
	localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic search;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic elem_full;
		logic table_empty;
		logic hit;
		logic miss_done;
		logic last;
		logic out_busy;
	} status_t;

	function automatic logic [SPAN_W-1:0] sat_span(input logic [CNT_W-1:0] s);
		logic [31:0] w;
		w = 32'(s);
		if (w > 32'(SPAN_MAX))
			return SPAN_MAX;
		else
			return SPAN_W'(w);
	endfunction

endpackage

>>> src/mevs_ctrl.sv
// controller state machine: accept, table search, commit and result hand-off
`timescale 1ns / 1ps

module mevs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  mevs_pkg::status_t status,
	output mevs_pkg::cmd_t    cmd
);

	mevs_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mevs_pkg::ST_IDLE;
		else
			state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			mevs_pkg::ST_IDLE: begin
				if (item_valid) begin
					if (status.elem_full || status.table_empty)
						state_next = mevs_pkg::ST_COMMIT;
					else
						state_next = mevs_pkg::ST_SEARCH;
				end
			end
			mevs_pkg::ST_SEARCH: begin
				if (status.hit || status.miss_done)
					state_next = mevs_pkg::ST_COMMIT;
			end
			mevs_pkg::ST_COMMIT: begin
				// a last request waits until the result register is free
				if (!(status.last && status.out_busy))
					state_next = mevs_pkg::ST_IDLE;
			end
			default: state_next = mevs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall = 1'b1;
		cmd        = '0;
		unique case (state_q)
			mevs_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				cmd.load   = item_valid;
			end
			mevs_pkg::ST_SEARCH: begin
				cmd.search = 1'b1;
			end
			mevs_pkg::ST_COMMIT: begin
				cmd.commit = !(status.last && status.out_busy);
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

endmodule

>>> src/mevs_datapath.sv
// datapath: key memory, sequential search, span tracking and result register
`timescale 1ns / 1ps

module mevs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [mevs_pkg::VALUE_W-1:0] value,
	input  logic                                last,
	input  mevs_pkg::cmd_t                      cmd,
	output mevs_pkg::status_t                   status,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [mevs_pkg::SPAN_W-1:0]         max_span,
	output logic                                overflow
);

	logic [mevs_pkg::ENTRY_W-1:0] key_mem_q [mevs_pkg::MAX_ELEMENTS];
	logic [mevs_pkg::ENTRY_W-1:0] rd_data_s1;

	logic [mevs_pkg::VALUE_W-1:0] value_q;
	logic                         last_q;
	logic [mevs_pkg::CNT_W-1:0]   count_q;
	logic [mevs_pkg::CNT_W-1:0]   idx_q;
	logic [mevs_pkg::CNT_W-1:0]   best_q;
	logic                         ovf_q;
	logic [mevs_pkg::CNT_W-1:0]   rd_ptr_q;
	logic                         cmp_valid_q;
	logic                         found_q;
	logic [mevs_pkg::CNT_W-1:0]   span_q;

	logic                         result_valid_q;
	logic [mevs_pkg::SPAN_W-1:0]  max_span_q;
	logic                         overflow_q;

	logic                         issue;
	logic                         key_match;
	logic                         elem_full;
	logic [mevs_pkg::CNT_W-1:0]   span_cur;
	logic [mevs_pkg::CNT_W-1:0]   best_next;
	logic                         ovf_next;
	logic [mevs_pkg::IDX_W-1:0]   hit_first;

	assign elem_full = idx_q >= mevs_pkg::CNT_W'(mevs_pkg::MAX_ELEMENTS);
	assign issue     = cmd.search && (rd_ptr_q < count_q);
	assign key_match = cmp_valid_q &&
		(rd_data_s1[mevs_pkg::ENTRY_W-1 -: mevs_pkg::VALUE_W] == value_q);
	assign hit_first = rd_data_s1[mevs_pkg::IDX_W-1:0];

	assign span_cur  = found_q ? span_q : mevs_pkg::CNT_W'(1);
	assign best_next = (!elem_full && span_cur > best_q) ? span_cur : best_q;
	assign ovf_next  = ovf_q | elem_full;

	assign status.elem_full   = elem_full;
	assign status.table_empty = count_q == '0;
	assign status.hit         = cmd.search && key_match;
	assign status.miss_done   = cmd.search && !cmp_valid_q && (rd_ptr_q == count_q);
	assign status.last        = last_q;
	assign status.out_busy    = result_valid_q && result_stall;

	// key memory: written on commit of a new value, read during search
	always_ff @(posedge clk) begin
		if (cmd.commit && !elem_full && !found_q)
			key_mem_q[count_q[mevs_pkg::IDX_W-1:0]] <= {value_q, idx_q[mevs_pkg::IDX_W-1:0]};
		if (issue)
			rd_data_s1 <= key_mem_q[rd_ptr_q[mevs_pkg::IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			last_q  <= last;
		end
		if (cmd.search && key_match)
			span_q <= idx_q - mevs_pkg::CNT_W'(hit_first) + mevs_pkg::CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			best_q      <= '0;
			ovf_q       <= 1'b0;
			rd_ptr_q    <= '0;
			cmp_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			cmp_valid_q <= issue;
			if (cmd.load) begin
				rd_ptr_q <= '0;
				found_q  <= 1'b0;
			end
			if (issue)
				rd_ptr_q <= rd_ptr_q + mevs_pkg::CNT_W'(1);
			if (cmd.search && key_match)
				found_q <= 1'b1;
			if (cmd.commit) begin
				if (last_q) begin
					count_q <= '0;
					idx_q   <= '0;
					best_q  <= '0;
					ovf_q   <= 1'b0;
				end else begin
					best_q <= best_next;
					ovf_q  <= ovf_next;
					if (!elem_full) begin
						idx_q <= idx_q + mevs_pkg::CNT_W'(1);
						if (!found_q)
							count_q <= count_q + mevs_pkg::CNT_W'(1);
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (cmd.commit && last_q)
			result_valid_q <= 1'b1;
		else if (!result_stall)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && last_q) begin
			max_span_q <= mevs_pkg::sat_span(best_next);
			overflow_q <= ovf_next;
		end
	end

	assign result_valid = result_valid_q;
	assign max_span     = max_span_q;
	assign overflow     = overflow_q;

endmodule

>>> src/max_equal_value_span_top.sv
// top level of the max equal value span block
`timescale 1ns / 1ps
//
// takes one signed 32-bit array element per request on the item channel
// (value, last) and returns one result per array on the result channel
// (max_span, overflow): the widest inclusive span between the first and the
// latest appearance of any value, and whether more than 1024 elements came
// each element is looked up by walking the stored distinct values one per
// cycle through a single-port key memory: a miss walks every stored entry,
// a hit stops at the matching entry, and an empty table or an element past
// capacity skips the search and goes straight to commit
// the result appears in the cycle after the last element's commit and is
// held in an output register; the next array's first element is accepted
// while it waits
// if the receiver stalls and another last element finishes, that element
// waits in commit with item_stall high until the result is taken
// reset clears all counters and the result valid; the key memory needs
// no clearing since only entries below the fill count are ever read

module max_equal_value_span_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic signed [mevs_pkg::VALUE_W-1:0] value,
	input  logic                                last,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [mevs_pkg::SPAN_W-1:0]         max_span,
	output logic                                overflow
);

	mevs_pkg::cmd_t    cmd;
	mevs_pkg::status_t status;

	mevs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	mevs_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.last         (last),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.max_span     (max_span),
		.overflow     (overflow)
	);

endmodule

>>> src/mevs_chk.sv
// port-level assertions for the max equal value span block, with bind
`timescale 1ns / 1ps

module mevs_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                item_valid,
	input logic                                item_stall,
	input logic                                result_valid,
	input logic                                result_stall,
	input logic [mevs_pkg::SPAN_W-1:0]         max_span,
	input logic                                overflow
);

	// a stalled result keeps its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(max_span) && $stable(overflow))
		else $error("stalled result changed");

	// every array holds at least one element, so the span is never zero
	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> max_span != '0)
		else $error("result with zero span");

	// an accepted request keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("request accepted on consecutive cycles");

	// a new result only comes out of a commit, during which requests stall
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result rose without a commit cycle");

endmodule

bind max_equal_value_span_top mevs_chk u_mevs_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.max_span     (max_span),
	.overflow     (overflow)
);
